@@ hdl/assert_macros.svh @@
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HTH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define HTH_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");
`else
`define HTH_ASSERT(lbl, prop)
`define HTH_ASSERT_RST(lbl, prop)
`endif
`endif

@@ hdl/hth_pkg.sv @@
// Shared constants, types and codes of the hourly temperature histogram.
package hth_pkg;
    localparam int HOURS       = 24;
    localparam int BINS        = 15;
    localparam int SHADE_STEPS = 6;
    localparam int MEM_DEPTH   = HOURS * BINS;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int HOUR_W      = 5;
    localparam int BIN_W       = 4;
    localparam int TEMP_W      = 7;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 23;
    localparam int TOT_W       = 24;
    localparam int MEAN_W      = 14;
    localparam int BAR_W       = 6;
    localparam int SHADE_W     = 3;
    localparam int SMUL_W      = 4;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int DVD_W       = 32;
    localparam int DSR_W       = 24;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_LOW   = 2'd0,
        CFG_BAR_LOW   = 2'd1,
        CFG_BAR_HIGH  = 2'd2,
        CFG_BAR_WIDTH = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_LOAD, DP_SRD, DP_SWR, DP_MRD, DP_MACC, DP_MUL1,
        DP_MUL2, DP_DMEAN, DP_SMEAN, DP_DBAR, DP_SBAR, DP_BRD, DP_BMUL,
        DP_DSHADE, DP_EMIT
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SRD, ST_SWR, ST_MRD, ST_MACC, ST_MUL1, ST_MUL2,
        ST_DMEAN, ST_WMEAN, ST_DBAR, ST_WBAR, ST_BRD, ST_BMUL, ST_DSHADE,
        ST_WSHADE, ST_EMIT
    } t_state;

    typedef struct packed {
        logic in_hour_ok;
        logic in_read;
        logic clr_last;
        logic bin_last;
        logic cnt_zero;
        logic max_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;
endpackage

@@ hdl/hth_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`include "assert_macros.svh"
module hth_div
    import hth_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);
    logic [DSR_W:0]     r_rem;
    logic [DVD_W-1:0]   r_quo;
    logic [DSR_W-1:0]   r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DSR_W:0]     trial;
    logic               fits;

    assign trial = {r_rem[DSR_W-1:0], r_quo[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dsr}) : trial;
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    `HTH_ASSERT(a_start_when_free, i_start |-> !r_busy)
    `HTH_ASSERT(a_busy_done_excl, !(r_busy && r_done))
    `HTH_ASSERT(a_done_after_run, $rose(r_done) |-> $past(r_busy) && r_cnt == '0)
endmodule

@@ hdl/hth_datapath.sv @@
// Datapath: bin memory, hour statistics, configuration, arithmetic and result register.
`include "assert_macros.svh"
module hth_datapath
    import hth_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_cmd,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_op,
    input  logic [HOUR_W-1:0]  i_hour,
    input  logic [TEMP_W-1:0]  i_temperature,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [BIN_W-1:0]   o_bin_index,
    output logic [CNT_W-1:0]   o_bin_count,
    output logic [SHADE_W-1:0] o_shade,
    output logic [CNT_W-1:0]   o_hour_samples,
    output logic               o_has_samples,
    output logic [MEAN_W-1:0]  o_mean_hundredths,
    output logic [BAR_W-1:0]   o_bar_length,
    output logic [TOT_W-1:0]   o_total_samples,
    output logic               o_last
);
    logic [CFG_W-1:0] r_bin_low, r_bar_low, r_bar_high;
    logic [BAR_W-1:0] r_bar_width;

    logic [CNT_W-1:0] r_mem [MEM_DEPTH];
    logic [CNT_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [SUM_W-1:0] r_hsum [HOURS];
    logic [CNT_W-1:0] r_hcnt [HOURS];
    logic [TOT_W-1:0] r_total;

    logic [HOUR_W-1:0] r_hour;
    logic [TEMP_W-1:0] r_temp;
    logic [BIN_W-1:0]  r_bin;
    logic [CNT_W-1:0]  r_max;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [SUM_W+6:0]  r_p100;
    logic [SUM_W-1:0]  r_base;
    logic [DSR_W-1:0]  r_den;
    logic              r_ge;
    logic [SUM_W+BAR_W-1:0] r_num;
    logic [DVD_W-1:0]  r_meannum;
    logic [MEAN_W-1:0] r_mean;
    logic [BAR_W-1:0]  r_bar;
    logic [CNT_W-1:0]  r_c;
    logic [CNT_W+SMUL_W-1:0] r_c6;
    logic              r_ovalid;

    logic [TEMP_W:0]   tdiff;
    logic [BIN_W-1:0]  sidx;
    logic [ADDR_W-1:0] saddr, baddr, raddr, waddr;
    logic              we;
    logic [CNT_W-1:0]  wdata;
    logic              bin_last, degenerate, out_free;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  dvd, quo;
    logic [DSR_W-1:0]  dsr;

    assign tdiff = {1'b0, r_temp} - {1'b0, r_bin_low};
    always_comb begin
        if (r_temp < r_bin_low) begin
            sidx = '0;
        end else if (tdiff >= (TEMP_W+1)'(BINS)) begin
            sidx = BIN_W'(BINS - 1);
        end else begin
            sidx = tdiff[BIN_W-1:0];
        end
    end
    assign saddr = ADDR_W'(r_hour) * ADDR_W'(BINS) + ADDR_W'(sidx);
    assign baddr = ADDR_W'(r_hour) * ADDR_W'(BINS) + ADDR_W'(r_bin);
    assign raddr = (i_cmd == DP_SRD) ? saddr : baddr;
    assign we    = (i_cmd == DP_CLR) || (i_cmd == DP_SWR);
    assign waddr = (i_cmd == DP_CLR) ? r_clr_addr : saddr;
    assign wdata = (i_cmd == DP_CLR) ? '0 :
                   ((r_rdata == CNT_MAX) ? r_rdata : r_rdata + 1'b1);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign bin_last   = r_bin == BIN_W'(BINS - 1);
    assign degenerate = r_bar_high <= r_bar_low;
    assign out_free   = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_low   <= CFG_W'(42);
            r_bar_low   <= CFG_W'(46);
            r_bar_high  <= CFG_W'(52);
            r_bar_width <= BAR_W'(40);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BIN_LOW:   r_bin_low   <= i_cfg_data;
                CFG_BAR_LOW:   r_bar_low   <= i_cfg_data;
                CFG_BAR_HIGH:  r_bar_high  <= i_cfg_data;
                CFG_BAR_WIDTH: r_bar_width <= i_cfg_data[BAR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_total    <= '0;
            r_ovalid   <= 1'b0;
            for (int h = 0; h < HOURS; h++) begin
                r_hsum[h] <= '0;
                r_hcnt[h] <= '0;
            end
        end else begin
            if (i_cmd == DP_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd == DP_SWR) begin
                if (r_hcnt[r_hour] != CNT_MAX) begin
                    r_hcnt[r_hour] <= r_hcnt[r_hour] + 1'b1;
                    r_hsum[r_hour] <= r_hsum[r_hour] + SUM_W'(r_temp);
                end
                if (r_total != TOTAL_MAX) begin
                    r_total <= r_total + 1'b1;
                end
            end
            if (i_cmd == DP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_hour <= i_hour;
                r_temp <= i_temperature;
                r_bin  <= '0;
                r_max  <= '0;
            end
            DP_MACC: begin
                if (r_rdata > r_max) begin
                    r_max <= r_rdata;
                end
                r_bin <= bin_last ? '0 : r_bin + 1'b1;
            end
            DP_MUL1: begin
                r_sum  <= r_hsum[r_hour];
                r_cnt  <= r_hcnt[r_hour];
                r_p100 <= r_hsum[r_hour] * (SUM_W+7)'(100);
                r_base <= SUM_W'(r_bar_low) * SUM_W'(r_hcnt[r_hour]);
                r_den  <= DSR_W'(r_hcnt[r_hour]) * DSR_W'(r_bar_high - r_bar_low);
                r_mean <= '0;
                r_bar  <= '0;
            end
            DP_MUL2: begin
                r_ge      <= r_sum >= r_base;
                r_num     <= (r_sum - r_base) * (SUM_W+BAR_W)'(r_bar_width);
                r_meannum <= DVD_W'(r_p100) + DVD_W'(r_cnt >> 1);
            end
            DP_SMEAN: r_mean <= quo[MEAN_W-1:0];
            DP_SBAR: begin
                if (!r_ge) begin
                    r_bar <= '0;
                end else if (degenerate) begin
                    r_bar <= r_bar_width;
                end else if (quo > DVD_W'(r_bar_width)) begin
                    r_bar <= r_bar_width;
                end else begin
                    r_bar <= quo[BAR_W-1:0];
                end
            end
            DP_BMUL: begin
                r_c  <= r_rdata;
                r_c6 <= r_rdata * (CNT_W+SMUL_W)'(SHADE_STEPS);
            end
            DP_EMIT: begin
                r_bin             <= bin_last ? '0 : r_bin + 1'b1;
                o_bin_index       <= r_bin;
                o_bin_count       <= r_c;
                o_shade           <= (r_max == '0) ? '0 : quo[SHADE_W-1:0];
                o_hour_samples    <= r_cnt;
                o_has_samples     <= r_cnt != '0;
                o_mean_hundredths <= r_mean;
                o_bar_length      <= r_bar;
                o_total_samples   <= r_total;
                o_last            <= bin_last;
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        dvd       = DVD_W'(r_c6);
        dsr       = DSR_W'(r_max);
        case (i_cmd)
            DP_DMEAN: begin
                div_start = 1'b1;
                dvd       = r_meannum;
                dsr       = DSR_W'(r_cnt);
            end
            DP_DBAR: begin
                div_start = 1'b1;
                dvd       = DVD_W'(r_num);
                dsr       = r_den;
            end
            DP_DSHADE: div_start = 1'b1;
            default: ;
        endcase
    end

    hth_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dsr),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    assign o_status.in_hour_ok = i_hour < HOUR_W'(HOURS);
    assign o_status.in_read    = i_op;
    assign o_status.clr_last   = r_clr_addr == ADDR_W'(MEM_DEPTH - 1);
    assign o_status.bin_last   = bin_last;
    assign o_status.cnt_zero   = r_cnt == '0;
    assign o_status.max_zero   = r_max == '0;
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = out_free;
    assign o_out_valid         = r_ovalid;

    `HTH_ASSERT(a_emit_free, (i_cmd == DP_EMIT) |-> out_free)
    `HTH_ASSERT(a_one_writer, !((i_cmd == DP_CLR) && (i_cmd == DP_SWR)))
    `HTH_ASSERT(a_last_is_top, (i_cmd == DP_EMIT) |=> (o_last == (o_bin_index == BIN_W'(BINS - 1))))
endmodule

@@ hdl/hth_ctrl.sv @@
// Controller state machine that sequences clearing, sample updates and readouts.
`include "assert_macros.svh"
module hth_ctrl
    import hth_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_op     o_cmd
);
    t_state r_state, n_state;
    logic   last_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (i_status.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid && i_status.in_hour_ok) begin
                    n_state = i_status.in_read ? ST_MRD : ST_SRD;
                end
            end
            ST_SRD:    n_state = ST_SWR;
            ST_SWR:    n_state = ST_IDLE;
            ST_MRD:    n_state = ST_MACC;
            ST_MACC:   n_state = i_status.bin_last ? ST_MUL1 : ST_MRD;
            ST_MUL1:   n_state = ST_MUL2;
            ST_MUL2:   n_state = i_status.cnt_zero ? ST_BRD : ST_DMEAN;
            ST_DMEAN:  n_state = ST_WMEAN;
            ST_WMEAN:  if (i_status.div_done) n_state = ST_DBAR;
            ST_DBAR:   n_state = ST_WBAR;
            ST_WBAR:   if (i_status.div_done) n_state = ST_BRD;
            ST_BRD:    n_state = ST_BMUL;
            ST_BMUL:   n_state = i_status.max_zero ? ST_EMIT : ST_DSHADE;
            ST_DSHADE: n_state = ST_WSHADE;
            ST_WSHADE: if (i_status.div_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.bin_last ? ST_IDLE : ST_BRD;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = DP_NOP;
        case (r_state)
            ST_CLEAR: o_cmd = DP_CLR;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = DP_LOAD;
            end
            ST_SRD:    o_cmd = DP_SRD;
            ST_SWR:    o_cmd = DP_SWR;
            ST_MRD:    o_cmd = DP_MRD;
            ST_MACC:   o_cmd = DP_MACC;
            ST_MUL1:   o_cmd = DP_MUL1;
            ST_MUL2:   o_cmd = DP_MUL2;
            ST_DMEAN:  o_cmd = DP_DMEAN;
            ST_WMEAN:  if (i_status.div_done) o_cmd = DP_SMEAN;
            ST_DBAR:   o_cmd = DP_DBAR;
            ST_WBAR:   if (i_status.div_done) o_cmd = DP_SBAR;
            ST_BRD:    o_cmd = DP_BRD;
            ST_BMUL:   o_cmd = DP_BMUL;
            ST_DSHADE: o_cmd = DP_DSHADE;
            ST_EMIT:   if (i_status.out_free) o_cmd = DP_EMIT;
            default: ;
        endcase
    end

    assign last_emit = (r_state == ST_EMIT) && i_status.out_free && i_status.bin_last;

    `HTH_ASSERT(a_no_request_in_clear, (r_state == ST_CLEAR) |-> !o_in_ready)
    `HTH_ASSERT(a_last_emit_ends, last_emit |=> r_state == ST_IDLE)
    `HTH_ASSERT_RST(a_reset_clears, !i_rst_n |=> r_state == ST_CLEAR)
endmodule

@@ hdl/hourly_temperature_histogram_top.sv @@
// Top level of the hourly temperature histogram.
// After reset the block sweeps its 360-entry bin memory to zero, one entry a
// cycle, and takes no request until the sweep ends; configuration writes are
// taken at any time. A sample request is accepted, its bin is read from memory
// and the count is written back. A readout request is accepted, the 15 bins
// are scanned and the products formed, then the serial divider computes the
// mean and bar when the hour has samples, then per bin the count is read and
// scaled, plus a division for the shade when any bin of the hour is non-zero.
// Results leave through a registered output that stays until taken, and an
// out-of-range hour is accepted and dropped.
module hourly_temperature_histogram_top
    import hth_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic [HOUR_W-1:0]    i_hour,
    input  logic [TEMP_W-1:0]    i_temperature,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BIN_W-1:0]     o_bin_index,
    output logic [CNT_W-1:0]     o_bin_count,
    output logic [SHADE_W-1:0]   o_shade,
    output logic [CNT_W-1:0]     o_hour_samples,
    output logic                 o_has_samples,
    output logic [MEAN_W-1:0]    o_mean_hundredths,
    output logic [BAR_W-1:0]     o_bar_length,
    output logic [TOT_W-1:0]     o_total_samples,
    output logic                 o_last
);
    t_dp_op     cmd;
    t_dp_status status;

    hth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hth_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_hour            (i_hour),
        .i_temperature     (i_temperature),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_bin_index       (o_bin_index),
        .o_bin_count       (o_bin_count),
        .o_shade           (o_shade),
        .o_hour_samples    (o_hour_samples),
        .o_has_samples     (o_has_samples),
        .o_mean_hundredths (o_mean_hundredths),
        .o_bar_length      (o_bar_length),
        .o_total_samples   (o_total_samples),
        .o_last            (o_last)
    );
endmodule
